>>> hw/rtl/hrt_pkg.sv
// Shared types, constants and helpers for the hotspot region table.
package hrt_pkg;

	localparam int MaxEntries = 16;
	localparam int IdxW       = $clog2(MaxEntries);
	localparam int CntW       = $clog2(MaxEntries + 1);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_EXPIRE = 2'd2;

	localparam logic [2:0] ST_MERGED   = 3'd0;
	localparam logic [2:0] ST_APPENDED = 3'd1;
	localparam logic [2:0] ST_REPLACED = 3'd2;
	localparam logic [2:0] ST_DROPPED  = 3'd3;
	localparam logic [2:0] ST_QENTRY   = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [23:0] box_center_x;
		logic signed [23:0] box_center_y;
		logic [22:0]        box_half_width;
		logic [22:0]        box_half_height;
		logic [15:0]        box_intensity;
		logic [31:0]        frame;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               hit;
		logic signed [23:0] out_center_x;
		logic signed [23:0] out_center_y;
		logic [22:0]        out_half_width;
		logic [22:0]        out_half_height;
		logic [15:0]        out_intensity;
		logic [31:0]        out_frame;
		logic [4:0]         entry_total;
		logic               last;
	} out_word_t;

	// One stored entry
	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [22:0]        hw;
		logic [22:0]        hh;
		logic [15:0]        str;
		logic [31:0]        tag;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic            load;      // capture input word
		logic            clr_scan;  // scan index to zero, reset min search
		logic            step;      // advance scan index
		logic            wr_merge;  // write merged entry at scan index
		logic            wr_new;    // write input box at write index
		logic            wr_sel_app; // write index = count (else min index)
		logic            cnt_inc;
		logic            cmp_copy;  // expire: keep entry, copy to keep index
		logic            cnt_set_keep;
		logic            emit;
		logic [2:0]      status;
		logic            hit;
		logic            pend_load; // hold query hit at scan index
		logic            pend_emit; // result word carries the held query hit
		logic            last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] opcode;
		logic       scan_end;   // scan index reached count
		logic       overlap;    // entry at scan index overlaps input box
		logic       tag_eq;
		logic       expired;
		logic       room;       // count below limit
		logic       beats_min;  // count > 0 and input intensity above minimum
		logic       any_hit;    // a query hit is being held
	} stat_t;

	// Bounding interval along one axis, center and half with saturation
	function automatic logic [46:0] merge_axis(logic signed [23:0] c1, logic [22:0] h1,
			logic signed [23:0] c2, logic [22:0] h2);
		logic signed [25:0] l1, r1, l2, r2, lo, hi;
		logic signed [26:0] s, d, nc;
		logic [23:0] cc;
		logic [22:0] nh;
		l1 = 26'(c1) - 26'($signed({1'b0, h1}));
		r1 = 26'(c1) + 26'($signed({1'b0, h1}));
		l2 = 26'(c2) - 26'($signed({1'b0, h2}));
		r2 = 26'(c2) + 26'($signed({1'b0, h2}));
		lo = (l1 < l2) ? l1 : l2;
		hi = (r1 > r2) ? r1 : r2;
		s  = 27'(lo) + 27'(hi);
		d  = 27'(hi) - 27'(lo);
		nc = s >>> 1;
		if (nc > 27'sd8388607)       cc = 24'h7FFFFF;
		else if (nc < -27'sd8388608) cc = 24'h800000;
		else                          cc = nc[23:0];
		d  = d >>> 1;
		nh = (d > 27'sd8388607) ? 23'h7FFFFF : d[22:0];
		return {cc, nh};
	endfunction

	// Strict overlap along one axis
	function automatic logic axis_overlap(logic signed [23:0] c1, logic [22:0] h1,
			logic signed [23:0] c2, logic [22:0] h2);
		logic signed [24:0] df;
		logic [24:0] ad;
		df = 25'(c1) - 25'(c2);
		ad = df[24] ? 25'(-df) : df;
		return ad < (25'(h1) + 25'(h2));
	endfunction

endpackage

>>> hw/rtl/hrt_datapath.sv
// Datapath of the hotspot region table: entry store, scan index, compare and merge.
module hrt_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	input  hrt_pkg::in_word_t  in_word,
	input  hrt_pkg::cmd_t      cmd,
	output hrt_pkg::stat_t     stat,
	output hrt_pkg::out_word_t res_word,
	output logic               res_strobe
);

	hrt_pkg::entry_t ent_q [hrt_pkg::MaxEntries];
	hrt_pkg::in_word_t in_q;
	logic [4:0] limit_q;
	logic [hrt_pkg::CntW-1:0] count_q, keep_q, scan_q;
	logic [hrt_pkg::IdxW-1:0] min_idx_q, scan_idx, wr_idx;
	logic [15:0] min_str_q;
	logic        any_hit_q;
	hrt_pkg::entry_t cur, wr_ent, pend_q;
	logic [46:0] mx, my;
	logic [hrt_pkg::CntW-1:0] lim_eff;
	logic [32:0] tag_p1;

	assign scan_idx = scan_q[hrt_pkg::IdxW-1:0];
	assign cur      = ent_q[scan_idx];

	// Effective limit clamped to 1..MaxEntries
	always_comb begin
		if (limit_q == 5'd0)
			lim_eff = hrt_pkg::CntW'(1);
		else if (32'(limit_q) > hrt_pkg::MaxEntries)
			lim_eff = hrt_pkg::CntW'(hrt_pkg::MaxEntries);
		else
			lim_eff = hrt_pkg::CntW'(limit_q);
	end

	// Compare and merge against the entry at the scan index
	assign mx = hrt_pkg::merge_axis(cur.cx, cur.hw, in_q.box_center_x, in_q.box_half_width);
	assign my = hrt_pkg::merge_axis(cur.cy, cur.hh, in_q.box_center_y, in_q.box_half_height);
	assign tag_p1 = 33'(cur.tag) + 33'd1;

	always_comb begin
		stat.opcode    = in_q.opcode;
		stat.scan_end  = (scan_q >= count_q);
		stat.overlap   = hrt_pkg::axis_overlap(cur.cx, cur.hw, in_q.box_center_x,
				in_q.box_half_width) && hrt_pkg::axis_overlap(cur.cy, cur.hh,
				in_q.box_center_y, in_q.box_half_height);
		stat.tag_eq    = (cur.tag == in_q.frame);
		stat.expired   = (33'(in_q.frame) > tag_p1);
		stat.room      = (count_q < lim_eff);
		stat.beats_min = (count_q != '0) && (in_q.box_intensity > min_str_q);
		stat.any_hit   = any_hit_q;
	end

	assign wr_idx = cmd.wr_sel_app ? count_q[hrt_pkg::IdxW-1:0] : min_idx_q;

	always_comb begin
		wr_ent.cx  = in_q.box_center_x;
		wr_ent.cy  = in_q.box_center_y;
		wr_ent.hw  = in_q.box_half_width;
		wr_ent.hh  = in_q.box_half_height;
		wr_ent.str = in_q.box_intensity;
		wr_ent.tag = in_q.frame;
	end

	// Entry store
	always_ff @(posedge clk) begin
		if (cmd.wr_merge) begin
			ent_q[scan_idx].cx  <= mx[46:23];
			ent_q[scan_idx].hw  <= mx[22:0];
			ent_q[scan_idx].cy  <= my[46:23];
			ent_q[scan_idx].hh  <= my[22:0];
			if (in_q.box_intensity > cur.str)
				ent_q[scan_idx].str <= in_q.box_intensity;
		end else if (cmd.wr_new) begin
			ent_q[wr_idx] <= wr_ent;
		end else if (cmd.cmp_copy) begin
			ent_q[keep_q[hrt_pkg::IdxW-1:0]] <= cur;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= in_word;
	end

	// Held query hit, sent once the next hit or the end of the scan is known
	always_ff @(posedge clk) begin
		if (cmd.pend_load)
			pend_q <= cur;
	end

	// Scan, minimum search and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= 5'd16;
			count_q   <= '0;
			keep_q    <= '0;
			scan_q    <= '0;
			min_idx_q <= '0;
			min_str_q <= '0;
			any_hit_q <= 1'b0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (cmd.clr_scan) begin
				scan_q    <= '0;
				keep_q    <= '0;
				min_idx_q <= '0;
				min_str_q <= 16'hFFFF;
				any_hit_q <= 1'b0;
			end else if (cmd.step) begin
				scan_q <= scan_q + 1'b1;
				if (scan_q == '0 || cur.str < min_str_q) begin
					min_idx_q <= scan_idx;
					min_str_q <= cur.str;
				end
				if (cmd.cmp_copy)
					keep_q <= keep_q + 1'b1;
				if (cmd.pend_load)
					any_hit_q <= 1'b1;
			end
			if (cmd.cnt_inc)
				count_q <= count_q + 1'b1;
			else if (cmd.cnt_set_keep)
				count_q <= keep_q;
		end
	end

	hrt_pkg::out_word_t res_q;
	logic res_v_q;
	logic [hrt_pkg::CntW-1:0] tot;

	// Count after this operation
	always_comb begin
		if (cmd.cnt_inc)
			tot = count_q + 1'b1;
		else if (cmd.cnt_set_keep)
			tot = keep_q;
		else
			tot = count_q;
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else
			res_v_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.status      <= cmd.status;
			res_q.hit         <= cmd.hit;
			res_q.entry_total <= 5'(tot);
			res_q.last        <= cmd.last;
			if (cmd.hit && cmd.wr_merge) begin
				res_q.out_center_x    <= mx[46:23];
				res_q.out_half_width  <= mx[22:0];
				res_q.out_center_y    <= my[46:23];
				res_q.out_half_height <= my[22:0];
				res_q.out_intensity   <= (in_q.box_intensity > cur.str) ?
						in_q.box_intensity : cur.str;
				res_q.out_frame       <= cur.tag;
			end else if (cmd.hit && cmd.wr_new) begin
				res_q.out_center_x    <= wr_ent.cx;
				res_q.out_center_y    <= wr_ent.cy;
				res_q.out_half_width  <= wr_ent.hw;
				res_q.out_half_height <= wr_ent.hh;
				res_q.out_intensity   <= wr_ent.str;
				res_q.out_frame       <= wr_ent.tag;
			end else if (cmd.pend_emit) begin
				res_q.out_center_x    <= pend_q.cx;
				res_q.out_center_y    <= pend_q.cy;
				res_q.out_half_width  <= pend_q.hw;
				res_q.out_half_height <= pend_q.hh;
				res_q.out_intensity   <= pend_q.str;
				res_q.out_frame       <= pend_q.tag;
			end else begin
				res_q.out_center_x    <= '0;
				res_q.out_center_y    <= '0;
				res_q.out_half_width  <= '0;
				res_q.out_half_height <= '0;
				res_q.out_intensity   <= '0;
				res_q.out_frame       <= '0;
			end
		end
	end

	assign res_word   = res_q;
	assign res_strobe = res_v_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hrt_pkg::CntW'(hrt_pkg::MaxEntries))
		else $error("entry count above table size");
	a_keep_le_scan: assert property (@(posedge clk) disable iff (!arst_n)
		keep_q <= scan_q || cmd.clr_scan)
		else $error("compaction index ahead of scan");
	a_grow_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> count_q < lim_eff)
		else $error("append beyond limit");
`endif

endmodule

>>> hw/rtl/hrt_ctrl.sv
// Controller state machine of the hotspot region table.
module hrt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hrt_pkg::stat_t stat,
	output hrt_pkg::cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load     = 1'b1;
					cmd.clr_scan = 1'b1;
					state_d      = S_SCAN;
				end
			end
			// One entry per cycle
			S_SCAN: begin
				if (stat.scan_end) begin
					state_d = S_FIN;
				end else begin
					cmd.step = 1'b1;
					unique case (stat.opcode)
						hrt_pkg::OP_ADD: begin
							if (stat.tag_eq && stat.overlap) begin
								cmd.wr_merge = 1'b1;
								cmd.emit     = 1'b1;
								cmd.status   = hrt_pkg::ST_MERGED;
								cmd.hit      = 1'b1;
								cmd.last     = 1'b1;
								cmd.step     = 1'b0;
								state_d      = S_IDLE;
							end
						end
						hrt_pkg::OP_QUERY: begin
							// hold this hit; the one held before it goes out now
							if (stat.overlap) begin
								cmd.pend_load = 1'b1;
								if (stat.any_hit) begin
									cmd.emit      = 1'b1;
									cmd.pend_emit = 1'b1;
									cmd.status    = hrt_pkg::ST_QENTRY;
									cmd.hit       = 1'b1;
								end
							end
						end
						hrt_pkg::OP_EXPIRE: begin
							cmd.cmp_copy = !stat.expired;
						end
						default: ;
					endcase
				end
			end
			S_FIN: begin
				cmd.emit   = 1'b1;
				cmd.last   = 1'b1;
				cmd.status = hrt_pkg::ST_DONE;
				state_d    = S_IDLE;
				unique case (stat.opcode)
					hrt_pkg::OP_ADD: begin
						if (stat.room) begin
							cmd.wr_new      = 1'b1;
							cmd.wr_sel_app  = 1'b1;
							cmd.cnt_inc     = 1'b1;
							cmd.status      = hrt_pkg::ST_APPENDED;
							cmd.hit         = 1'b1;
						end else if (stat.beats_min) begin
							cmd.wr_new  = 1'b1;
							cmd.status  = hrt_pkg::ST_REPLACED;
							cmd.hit     = 1'b1;
						end else begin
							cmd.status  = hrt_pkg::ST_DROPPED;
						end
					end
					hrt_pkg::OP_QUERY: begin
						// final held hit carries the last flag, else a plain done
						if (stat.any_hit) begin
							cmd.pend_emit = 1'b1;
							cmd.status    = hrt_pkg::ST_QENTRY;
							cmd.hit       = 1'b1;
						end
					end
					hrt_pkg::OP_EXPIRE: cmd.cnt_set_keep = 1'b1;
					default: ;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("load outside idle");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.wr_merge, cmd.wr_new, cmd.cmp_copy}) <= 1)
		else $error("two store writes in one cycle");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> state_q == S_IDLE)
		else $error("finish did not return to idle");
`endif

endmodule

>>> hw/rtl/hotspot_region_table_unit.sv
// Hotspot region table: ordered box table with add/merge, query and expire.
// While busy, each word scans the held entries (at most 16), one entry per cycle
// through the shared compare/merge datapath; a merging add ends early.
// The next word is taken only once busy is low; results are registered and come in
// the cycle after they are decided, the final one as busy falls; receiver cannot stall.
// Reset clears the count and sets the limit to 16; no clearing pass.
module hotspot_region_table_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  hrt_pkg::in_word_t  in_word,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	output logic               result_strobe,
	output hrt_pkg::out_word_t result
);

	hrt_pkg::cmd_t  cmd;
	hrt_pkg::stat_t stat;

	hrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	hrt_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_word    (in_word),
		.cmd        (cmd),
		.stat       (stat),
		.res_word   (result),
		.res_strobe (result_strobe)
	);

endmodule

>>> bench/hotspot_region_table_unit_test.sv
// Self-checking testbench for the hotspot region table: directed table, then random words.
module hotspot_region_table_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         HalfMax   = 8388607;
	localparam int         CtrMax    = 8388607;
	localparam int         CtrMin    = -8388608;
	localparam int         InW       = $bits(hrt_pkg::in_word_t);

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	hrt_pkg::in_word_t  in_word = '0;
	logic      cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic      result_strobe;
	hrt_pkg::out_word_t result;

	hotspot_region_table_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.in_word       (in_word),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.result_strobe (result_strobe),
		.result        (result)
	);

	always #1 clk = ~clk;

	// Shadow copy of the table
	longint    box_cx[hrt_pkg::MaxEntries];
	longint    box_cy[hrt_pkg::MaxEntries];
	longint    box_hw[hrt_pkg::MaxEntries];
	longint    box_hh[hrt_pkg::MaxEntries];
	longint    box_str[hrt_pkg::MaxEntries];
	longint    box_tag[hrt_pkg::MaxEntries];
	int        box_count = 0;
	int        limit_reg = 16;
	hrt_pkg::out_word_t expected_words[$];
	int        mismatches = 0;
	bit        no_idle = 1'b0;

	// Append one expected word at the tail
	function automatic void add_expected(hrt_pkg::out_word_t o);
		expected_words.insert(expected_words.size(), o);
	endfunction

	function automatic hrt_pkg::out_word_t entry_word(logic [2:0] st, int idx, bit lst);
		hrt_pkg::out_word_t o;
		o = '0;
		o.status = st;
		if (idx >= 0) begin
			o.hit             = 1'b1;
			o.out_center_x    = box_cx[idx][23:0];
			o.out_center_y    = box_cy[idx][23:0];
			o.out_half_width  = box_hw[idx][22:0];
			o.out_half_height = box_hh[idx][22:0];
			o.out_intensity   = box_str[idx][15:0];
			o.out_frame       = box_tag[idx][31:0];
		end
		o.entry_total = box_count[4:0];
		o.last        = lst;
		return o;
	endfunction

	function automatic bit overlaps(int i, longint cx, longint cy, longint hw, longint hh);
		longint dx, dy;
		dx = box_cx[i] - cx;
		dy = box_cy[i] - cy;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return (dx < box_hw[i] + hw) && (dy < box_hh[i] + hh);
	endfunction

	// Bounding interval on one axis, center floored, both saturated
	task automatic merge_axis_pred(inout longint c1, inout longint h1, input longint c2,
			input longint h2);
		longint lo, hi, nc, nh;
		lo = (c1 - h1 < c2 - h2) ? c1 - h1 : c2 - h2;
		hi = (c1 + h1 > c2 + h2) ? c1 + h1 : c2 + h2;
		nc = (lo + hi) >>> 1;
		nh = (hi - lo) >>> 1;
		if (nc > CtrMax) nc = CtrMax;
		if (nc < CtrMin) nc = CtrMin;
		if (nh > HalfMax) nh = HalfMax;
		c1 = nc;
		h1 = nh;
	endtask

	// Update the shadow table for one accepted word and queue its results
	task automatic predict_table(input hrt_pkg::in_word_t w);
		longint cx, cy, hw, hh, inten, fr;
		int     lim, m, k, hits;
		hrt_pkg::out_word_t o;
		cx = w.box_center_x;
		cy = w.box_center_y;
		hw = w.box_half_width;
		hh = w.box_half_height;
		inten = w.box_intensity;
		fr = w.frame;
		case (w.opcode)
			hrt_pkg::OP_ADD: begin
				lim = (limit_reg == 0) ? 1 : limit_reg;
				if (lim > hrt_pkg::MaxEntries) lim = hrt_pkg::MaxEntries;
				for (int i = 0; i < box_count; i++) begin
					if (box_tag[i] == fr && overlaps(i, cx, cy, hw, hh)) begin
						merge_axis_pred(box_cx[i], box_hw[i], cx, hw);
						merge_axis_pred(box_cy[i], box_hh[i], cy, hh);
						if (inten > box_str[i]) box_str[i] = inten;
						add_expected(entry_word(hrt_pkg::ST_MERGED, i, 1'b1));
						return;
					end
				end
				if (box_count < lim) begin
					box_cx[box_count] = cx;
					box_cy[box_count] = cy;
					box_hw[box_count] = hw;
					box_hh[box_count] = hh;
					box_str[box_count] = inten;
					box_tag[box_count] = fr;
					box_count++;
					add_expected(entry_word(hrt_pkg::ST_APPENDED, box_count - 1, 1'b1));
					return;
				end
				m = 0;
				for (int i = 1; i < box_count; i++)
					if (box_str[i] < box_str[m]) m = i;
				if (box_count > 0 && inten > box_str[m]) begin
					box_cx[m] = cx;
					box_cy[m] = cy;
					box_hw[m] = hw;
					box_hh[m] = hh;
					box_str[m] = inten;
					box_tag[m] = fr;
					add_expected(entry_word(hrt_pkg::ST_REPLACED, m, 1'b1));
				end else begin
					add_expected(entry_word(hrt_pkg::ST_DROPPED, -1, 1'b1));
				end
			end
			hrt_pkg::OP_QUERY: begin
				hits = 0;
				for (int i = 0; i < box_count; i++) begin
					if (overlaps(i, cx, cy, hw, hh)) begin
						add_expected(entry_word(hrt_pkg::ST_QENTRY, i, 1'b0));
						hits++;
					end
				end
				if (hits == 0) begin
					add_expected(entry_word(hrt_pkg::ST_DONE, -1, 1'b1));
				end else begin
					o = expected_words.pop_back();
					o.last = 1'b1;
					add_expected(o);
				end
			end
			default: begin
				if (w.opcode == hrt_pkg::OP_EXPIRE) begin
					k = 0;
					for (int i = 0; i < box_count; i++) begin
						if (fr > box_tag[i] + 1) continue;
						box_cx[k] = box_cx[i];
						box_cy[k] = box_cy[i];
						box_hw[k] = box_hw[i];
						box_hh[k] = box_hh[i];
						box_str[k] = box_str[i];
						box_tag[k] = box_tag[i];
						k++;
					end
					box_count = k;
				end
				add_expected(entry_word(hrt_pkg::ST_DONE, -1, 1'b1));
			end
		endcase
	endtask

	// Result checker: every strobed word against the oldest expectation
	always @(posedge clk) begin
		hrt_pkg::out_word_t e;
		if (arst_n && result_strobe) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: %h", result);
			end else begin
				e = expected_words.pop_front();
				if (result.status !== e.status || result.hit !== e.hit ||
						result.out_center_x !== e.out_center_x ||
						result.out_center_y !== e.out_center_y ||
						result.out_half_width !== e.out_half_width ||
						result.out_half_height !== e.out_half_height ||
						result.out_intensity !== e.out_intensity ||
						result.out_frame !== e.out_frame ||
						result.entry_total !== e.entry_total || result.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("exp st=%0d hit=%0d cx=%0d cy=%0d hw=%0d hh=%0d i=%0d f=%0d n=%0d l=%0d",
							e.status, e.hit, e.out_center_x, e.out_center_y, e.out_half_width,
							e.out_half_height, e.out_intensity, e.out_frame, e.entry_total,
							e.last);
						$display("got st=%0d hit=%0d cx=%0d cy=%0d hw=%0d hh=%0d i=%0d f=%0d n=%0d l=%0d",
							result.status, result.hit, result.out_center_x, result.out_center_y,
							result.out_half_width, result.out_half_height, result.out_intensity,
							result.out_frame, result.entry_total, result.last);
					end
				end
			end
		end
	end

	// Offer one word, with random gaps unless no_idle is set, and wait until busy is low again
	task automatic send_word(input hrt_pkg::in_word_t w);
		while (!no_idle && $urandom_range(99) < 37) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		predict_table(w);
	endtask

	// Limit write once the table has gone quiet
	task automatic write_limit(input int v);
		start <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[4:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_reg = v;
	endtask

	function automatic hrt_pkg::in_word_t mk_word(logic [1:0] op, int cx, int cy, int hw,
			int hh, int inten, logic [31:0] fr);
		hrt_pkg::in_word_t w;
		w.opcode          = op;
		w.box_center_x    = cx[23:0];
		w.box_center_y    = cy[23:0];
		w.box_half_width  = hw[22:0];
		w.box_half_height = hh[22:0];
		w.box_intensity   = inten[15:0];
		w.frame           = fr;
		return w;
	endfunction

	typedef struct {
		hrt_pkg::in_word_t w;
		bit         typed;
		logic [2:0] t_status;
		logic [4:0] t_total;
	} stim_row_t;

	function automatic hrt_pkg::in_word_t random_word(int frame_now);
		hrt_pkg::in_word_t w;
		int       cl;
		if ($urandom_range(99) < 15) begin
			w = InW'({$urandom, $urandom, $urandom, $urandom, $urandom});
			return w;
		end
		cl = $urandom_range(3);
		w.box_center_x    = 24'(cl * 2048 - 3072 + $signed($urandom_range(2048)) - 1024);
		w.box_center_y    = 24'(cl * 1024 - 1536 + $signed($urandom_range(2048)) - 1024);
		w.box_half_width  = 23'($urandom_range(1536));
		w.box_half_height = 23'($urandom_range(1536));
		w.box_intensity   = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(6) * 1000);
		w.frame           = 32'(frame_now - $urandom_range(1));
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: w.opcode = hrt_pkg::OP_ADD;
			12, 13, 14, 15, 16: w.opcode = hrt_pkg::OP_QUERY;
			17, 18: begin
				w.opcode = hrt_pkg::OP_EXPIRE;
				w.frame  = 32'(frame_now + $urandom_range(2));
			end
			default: w.opcode = OP_UNUSED;
		endcase
		return w;
	endfunction

	// Stimulus
	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		int        limits[6] = '{0, 31, 2, 1, 16, 5};
		int        frame_now;
		int        sent;

		r.typed = 1'b0; r.t_status = '0; r.t_total = '0;
		// Empty table: query, expire and the unused opcode all finish with no hit
		r.w = mk_word(hrt_pkg::OP_QUERY, 0, 0, HalfMax, HalfMax, 0, 0);
		r.typed = 1'b1; r.t_status = hrt_pkg::ST_DONE; r.t_total = 5'd0;
		rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_EXPIRE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		rows.insert(rows.size(), r);
		r.w = mk_word(OP_UNUSED, -1, -1, HalfMax, HalfMax, 16'hFFFF, 32'hFFFF_FFFF);
		rows.insert(rows.size(), r);
		r.typed = 1'b0;
		r.w = mk_word(hrt_pkg::OP_ADD, 0, 0, 256, 256, 100, 5); rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_ADD, 128, -64, 256, 64, 50, 5); rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_ADD, 0, 0, 256, 256, 7, 6); rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_ADD, CtrMax, CtrMin, HalfMax, HalfMax, 16'hFFFF,
				32'hFFFF_FFFF);
		rows.insert(rows.size(), r);
		// Merge far enough apart that the half width saturates
		r.w = mk_word(hrt_pkg::OP_ADD, -8388000, CtrMin, HalfMax, HalfMax, 3, 32'hFFFF_FFFF);
		rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_ADD, CtrMax, CtrMax, 1, 1, 9, 32'hFFFF_FFFF);
		rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_ADD, -3, 5, 0, 0, 0, 5); rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0); rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_QUERY, 0, 0, HalfMax, HalfMax, 0, 0);
		rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_QUERY, -100000, 100000, 10, 10, 0, 0);
		rows.insert(rows.size(), r);
		r.w = mk_word(OP_UNUSED, 0, 0, 0, 0, 0, 0); rows.insert(rows.size(), r);
		// Tag 5 ages out at frame 7, tag 6 at frame 8, the all-ones tag never
		r.w = mk_word(hrt_pkg::OP_EXPIRE, 0, 0, 0, 0, 0, 7); rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_EXPIRE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		rows.insert(rows.size(), r);
		r.w = mk_word(hrt_pkg::OP_QUERY, CtrMin, CtrMax, HalfMax, HalfMax, 0, 0);
		rows.insert(rows.size(), r);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].w);
			if (rows[i].typed) begin
				expected_words.pop_back();
				add_expected(entry_word(rows[i].t_status, -1, 1'b1));
				expected_words[$].entry_total = rows[i].t_total;
			end
		end

		// Random phases, each under its own limit
		frame_now = 10;
		sent = 0;
		foreach (limits[p]) begin
			write_limit(limits[p]);
			for (int j = 0; j < 19; j++) begin
				no_idle = (sent >= 40 && sent < 70);
				if ($urandom_range(9) == 0) frame_now++;
				send_word(random_word(frame_now));
				sent++;
			end
		end
		start <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/hrt_pkg.sv
hw/rtl/hrt_datapath.sv
hw/rtl/hrt_ctrl.sv
hw/rtl/hotspot_region_table_unit.sv
bench/hotspot_region_table_unit_test.sv
